// ----- rtl/core/hla_pkg.sv -----
// ----------------------------------------------------------------------------
// hla_pkg
// Shared constants, widths and status codes of the hole list allocator.
// ----------------------------------------------------------------------------
package hla_pkg;

    localparam int MEM_BYTES = 65536;
    localparam int MAX_HOLES = 32;

    localparam int ADDR_W = 16;
    localparam int LEN_W  = 17;
    localparam int END_W  = 18;
    localparam int IDX_W  = $clog2(MAX_HOLES);
    localparam int CNT_W  = $clog2(MAX_HOLES + 1);
    localparam int ENTRY_W = ADDR_W + LEN_W;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_IGNORED = 2'd3;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

endpackage

// ----- rtl/core/hla_req_if.sv -----
// ----------------------------------------------------------------------------
// hla_req_if
// Request channel of the hole list allocator: valid, ready and payload.
// ----------------------------------------------------------------------------
interface hla_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [16:0] req_size;
    logic [15:0] req_addr;

    modport source (output valid, output func, output req_size, output req_addr,
                    input ready);
    modport sink (input valid, input func, input req_size, input req_addr,
                  output ready);
endinterface

// ----- rtl/core/hla_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hla_rsp_if
// Response channel of the hole list allocator: valid, ready and payload.
// ----------------------------------------------------------------------------
interface hla_rsp_if;
    logic        valid;
    logic        ready;
    logic [15:0] alloc_addr;
    logic [1:0]  status;

    modport source (output valid, output alloc_addr, output status, input ready);
    modport sink (input valid, input alloc_addr, input status, output ready);
endinterface

// ----- rtl/core/hole_list_allocator_core.sv -----
// ----------------------------------------------------------------------------
// hole_list_allocator_core
// Address-sorted free hole table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// One request is handled at a time. A request scans the hole table held in a
// single RAM, one entry per cycle (fewer entries when a free finds its place
// early), then passes through a decision state, and an insertion or removal
// shifts the entries above the touched slot, one per cycle, through the RAM's
// single read and write port. The result waits in an output register, and the
// next request is taken while it waits. After reset the S_INIT state seeds the
// table with the single hole covering all memory before the first request is
// taken.
module hole_list_allocator_core (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,
    hla_req_if.sink    req,
    hla_rsp_if.source  rsp
);
    import hla_pkg::*;

    localparam logic [2:0] S_INIT   = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DECIDE = 3'd3;
    localparam logic [2:0] S_REMOVE = 3'd4;
    localparam logic [2:0] S_INSERT = 3'd5;
    localparam logic [2:0] S_RESP   = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [1:0]        policy_reg;
    logic [CNT_W-1:0]  count_reg, count_next;

    // request held for the whole operation
    logic              func_reg, func_next;
    logic [LEN_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [LEN_W-1:0]  end_reg, end_next;

    // scan pipeline
    logic [CNT_W-1:0]  iss_reg, iss_next;
    logic              vld_reg, vld_next;
    logic [IDX_W-1:0]  eidx_reg, eidx_next;

    // alloc pick
    logic              found_reg, found_next;
    logic [IDX_W-1:0]  pick_reg, pick_next;
    logic [ADDR_W-1:0] pick_start_reg, pick_start_next;
    logic [LEN_W-1:0]  pick_len_reg, pick_len_next;

    // free neighbours
    logic              has_prev_reg, has_prev_next;
    logic [ADDR_W-1:0] prev_start_reg, prev_start_next;
    logic [LEN_W-1:0]  prev_len_reg, prev_len_next;
    logic              has_next_reg, has_next_next;
    logic [ADDR_W-1:0] next_start_reg, next_start_next;
    logic [LEN_W-1:0]  next_len_reg, next_len_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;

    // shift pipeline
    logic [CNT_W-1:0]  sh_reg, sh_next;
    logic              shv_reg, shv_next;
    logic [IDX_W-1:0]  shw_reg, shw_next;
    logic [CNT_W-1:0]  base_reg, base_next;

    // result
    logic [1:0]        status_reg, status_next;
    logic [ADDR_W-1:0] grant_reg, grant_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0] rsp_addr_reg, rsp_addr_next;
    logic [1:0]        rsp_status_reg, rsp_status_next;

    // RAM port
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [ADDR_W-1:0]  d_start;
    logic [LEN_W-1:0]   d_len;

    // decision arithmetic
    logic [END_W-1:0]  req_sum;
    logic [END_W-1:0]  prev_end, next_end, fr_end, ne_prev, ne_next;
    logic              join_prev, join_next;

    hla_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_HOLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign d_start = ram_rdata[ENTRY_W-1:LEN_W];
    assign d_len   = ram_rdata[LEN_W-1:0];

    assign req.ready      = (state_reg == S_IDLE);
    assign rsp.valid      = rsp_valid_reg;
    assign rsp.alloc_addr = rsp_addr_reg;
    assign rsp.status     = rsp_status_reg;

    // clamp the freed range at the end of memory
    assign req_sum = END_W'(req.req_addr) + END_W'(req.req_size);

    // neighbour ends for the merge decision
    assign prev_end  = END_W'(prev_start_reg) + END_W'(prev_len_reg);
    assign next_end  = END_W'(next_start_reg) + END_W'(next_len_reg);
    assign fr_end    = END_W'(end_reg);
    assign join_prev = has_prev_reg && (prev_end >= END_W'(addr_reg));
    assign join_next = has_next_reg && (END_W'(next_start_reg) <= fr_end);

    always_comb
    begin
        // union end on the merge with the previous hole
        ne_prev = (fr_end > prev_end) ? fr_end : prev_end;
        if (join_next && (next_end > ne_prev))
        begin
            ne_prev = next_end;
        end
        ne_next = (fr_end > next_end) ? fr_end : next_end;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        func_next       = func_reg;
        size_next       = size_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        iss_next        = iss_reg;
        vld_next        = 1'b0;
        eidx_next       = eidx_reg;
        found_next      = found_reg;
        pick_next       = pick_reg;
        pick_start_next = pick_start_reg;
        pick_len_next   = pick_len_reg;
        has_prev_next   = has_prev_reg;
        prev_start_next = prev_start_reg;
        prev_len_next   = prev_len_reg;
        has_next_next   = has_next_reg;
        next_start_next = next_start_reg;
        next_len_next   = next_len_reg;
        pos_next        = pos_reg;
        sh_next         = sh_reg;
        shv_next        = 1'b0;
        shw_next        = shw_reg;
        base_next       = base_reg;
        status_next     = status_reg;
        grant_next      = grant_reg;
        rsp_valid_next  = rsp_valid_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;

        // drop the result once the sink takes it
        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                // seed the single hole covering the whole memory
                ram_we     = 1'b1;
                ram_waddr  = '0;
                ram_wdata  = {ADDR_W'(0), LEN_W'(MEM_BYTES)};
                count_next = CNT_W'(1);
                state_next = S_IDLE;
            end

            S_IDLE:
            begin
                if (req.valid)
                begin
                    func_next     = req.func;
                    size_next     = req.req_size;
                    addr_next     = req.req_addr;
                    end_next      = (req_sum > END_W'(MEM_BYTES)) ?
                                    LEN_W'(MEM_BYTES) : LEN_W'(req_sum);
                    iss_next      = '0;
                    found_next    = 1'b0;
                    has_prev_next = 1'b0;
                    has_next_next = 1'b0;
                    pos_next      = count_reg;
                    status_next   = ST_OK;
                    grant_next    = '0;
                    if ((req.func == FUNC_FREE) &&
                        ((req.req_size == '0) ||
                         ({1'b0, req.req_addr} >= LEN_W'(MEM_BYTES))))
                    begin
                        status_next = ST_IGNORED;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                // issue the next read, evaluate the entry read last cycle
                ram_raddr = iss_reg[IDX_W-1:0];
                if (iss_reg < count_reg)
                begin
                    vld_next  = 1'b1;
                    eidx_next = iss_reg[IDX_W-1:0];
                    iss_next  = iss_reg + CNT_W'(1);
                end
                if (vld_reg)
                begin
                    if (func_reg == FUNC_ALLOC)
                    begin
                        if (d_len >= size_reg)
                        begin
                            if (!found_reg)
                            begin
                                found_next      = 1'b1;
                                pick_next       = eidx_reg;
                                pick_start_next = d_start;
                                pick_len_next   = d_len;
                                if ((policy_reg != POL_BEST) && (policy_reg != POL_WORST))
                                begin
                                    vld_next   = 1'b0;
                                    state_next = S_DECIDE;
                                end
                            end
                            else if (((policy_reg == POL_BEST) && (d_len < pick_len_reg)) ||
                                     ((policy_reg == POL_WORST) && (d_len > pick_len_reg)))
                            begin
                                pick_next       = eidx_reg;
                                pick_start_next = d_start;
                                pick_len_next   = d_len;
                            end
                        end
                    end
                    else
                    begin
                        if (d_start == addr_reg)
                        begin
                            vld_next    = 1'b0;
                            status_next = ST_IGNORED;
                            state_next  = S_RESP;
                        end
                        else if (d_start > addr_reg)
                        begin
                            vld_next        = 1'b0;
                            pos_next        = CNT_W'(eidx_reg);
                            has_next_next   = 1'b1;
                            next_start_next = d_start;
                            next_len_next   = d_len;
                            state_next      = S_DECIDE;
                        end
                        else
                        begin
                            has_prev_next   = 1'b1;
                            prev_start_next = d_start;
                            prev_len_next   = d_len;
                        end
                    end
                end
                else if (iss_reg >= count_reg)
                begin
                    // every entry seen without an early stop
                    vld_next   = 1'b0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                if (func_reg == FUNC_ALLOC)
                begin
                    if (!found_reg)
                    begin
                        status_next = ST_NOFIT;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        grant_next = pick_start_reg;
                        if (pick_len_reg == size_reg)
                        begin
                            base_next  = CNT_W'(pick_reg);
                            sh_next    = CNT_W'(pick_reg);
                            state_next = S_REMOVE;
                        end
                        else
                        begin
                            // shrink the hole from the front
                            ram_we     = 1'b1;
                            ram_waddr  = pick_reg;
                            ram_wdata  = {pick_start_reg + size_reg[ADDR_W-1:0],
                                          pick_len_reg - size_reg};
                            state_next = S_RESP;
                        end
                    end
                end
                else if (join_prev)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = IDX_W'(pos_reg - CNT_W'(1));
                    ram_wdata  = {prev_start_reg, LEN_W'(ne_prev - END_W'(prev_start_reg))};
                    if (join_next)
                    begin
                        sh_next    = pos_reg;
                        base_next  = pos_reg;
                        state_next = S_REMOVE;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else if (join_next)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[IDX_W-1:0];
                    ram_wdata  = {addr_reg, LEN_W'(ne_next - END_W'(addr_reg))};
                    state_next = S_RESP;
                end
                else if (count_reg >= CNT_W'(MAX_HOLES))
                begin
                    status_next = ST_FULL;
                    state_next  = S_RESP;
                end
                else
                begin
                    sh_next    = count_reg;
                    base_next  = pos_reg;
                    state_next = S_INSERT;
                end
            end

            S_REMOVE:
            begin
                // move entry sh+1 down to sh, one per cycle
                ram_raddr = IDX_W'(sh_reg + CNT_W'(1));
                if ((sh_reg + CNT_W'(1)) < count_reg)
                begin
                    shv_next = 1'b1;
                    shw_next = sh_reg[IDX_W-1:0];
                    sh_next  = sh_reg + CNT_W'(1);
                end
                if (shv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = shw_reg;
                    ram_wdata = ram_rdata;
                end
                else if ((sh_reg + CNT_W'(1)) >= count_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_RESP;
                end
            end

            S_INSERT:
            begin
                // move entry sh-1 up to sh, from the top down to the slot
                ram_raddr = IDX_W'(sh_reg - CNT_W'(1));
                if (sh_reg > base_reg)
                begin
                    shv_next = 1'b1;
                    shw_next = sh_reg[IDX_W-1:0];
                    sh_next  = sh_reg - CNT_W'(1);
                end
                if (shv_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = shw_reg;
                    ram_wdata = ram_rdata;
                end
                else if (sh_reg <= base_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = base_reg[IDX_W-1:0];
                    ram_wdata  = {addr_reg, end_reg - LEN_W'(addr_reg)};
                    count_next = count_reg + CNT_W'(1);
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_addr_next   = (status_reg == ST_OK) ? grant_reg : '0;
                    rsp_status_next = status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            policy_reg    <= POL_FIRST;
            count_reg     <= CNT_W'(1);
            vld_reg       <= 1'b0;
            shv_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            vld_reg       <= vld_next;
            shv_reg       <= shv_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                policy_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        size_reg       <= size_next;
        addr_reg       <= addr_next;
        end_reg        <= end_next;
        iss_reg        <= iss_next;
        eidx_reg       <= eidx_next;
        found_reg      <= found_next;
        pick_reg       <= pick_next;
        pick_start_reg <= pick_start_next;
        pick_len_reg   <= pick_len_next;
        has_prev_reg   <= has_prev_next;
        prev_start_reg <= prev_start_next;
        prev_len_reg   <= prev_len_next;
        has_next_reg   <= has_next_next;
        next_start_reg <= next_start_next;
        next_len_reg   <= next_len_next;
        pos_reg        <= pos_next;
        sh_reg         <= sh_next;
        shw_reg        <= shw_next;
        base_reg       <= base_next;
        status_reg     <= status_next;
        grant_reg      <= grant_next;
        rsp_addr_reg   <= rsp_addr_next;
        rsp_status_reg <= rsp_status_next;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_HOLES))
        else $error("hole count beyond table depth");

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !ram_we)
        else $error("table written while idle");

    a_idle_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |=> $stable(count_reg))
        else $error("hole count changed on request acceptance");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && !rsp.ready) |=> (rsp_valid_reg && $stable(rsp_addr_reg) &&
                                          $stable(rsp_status_reg)))
        else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/core/hla_ram.sv -----
// ----------------------------------------------------------------------------
// hla_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module hla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- tb/tb_hla_chan_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hla_chan_if
// Helper types for the allocator testbench: one request row and its result.
// ----------------------------------------------------------------------------
package tb_hla_types_pkg;
    typedef struct packed {
        logic        func;
        logic [16:0] req_size;
        logic [15:0] req_addr;
    } alloc_req_t;

    typedef struct packed {
        logic [15:0] alloc_addr;
        logic [1:0]  status;
    } alloc_rsp_t;
endpackage

// ----- tb/tb_hole_list_allocator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hole_list_allocator_core
// Self-checking bench for the hole list allocator core.
// A directed table of requests runs under an unused policy value, and random
// allocate and free traffic runs under each fit policy. A behavioural hole table
// predicts every response, and the responses are checked in order against the predicted ones.
// ----------------------------------------------------------------------------
module tb_hole_list_allocator_core;
    import hla_pkg::*;
    import tb_hla_types_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    hla_req_if req ();
    hla_rsp_if rsp ();

    hole_list_allocator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req.sink),
        .rsp       (rsp.source)
    );

    // Predictor state: a sorted copy of the free hole table.
    logic [15:0] pred_start [MAX_HOLES];
    logic [16:0] pred_len [MAX_HOLES];
    int          pred_count;
    logic [1:0]  pred_policy;

    alloc_rsp_t  pending_rsps [$];
    int          error_count;
    int          cycle_count;

    // Idle mix: sender and receiver idle percentages.
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          hold_off_rsp;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Watchdog on the cycle counter.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Shift entries down from idx and drop the top one.
    function automatic void drop_hole(input int idx);
        for (int i = idx; i + 1 < pred_count; i++)
        begin
            pred_start[i] = pred_start[i + 1];
            pred_len[i]   = pred_len[i + 1];
        end
        pred_count--;
    endfunction

    function automatic alloc_rsp_t predict_alloc(input logic [16:0] size);
        alloc_rsp_t r;
        bit         found;
        int         pick;
        r = '0;
        found = 1'b0;
        pick = 0;
        for (int i = 0; i < pred_count; i++)
        begin
            if (pred_len[i] < size)
                continue;
            if (!found)
            begin
                found = 1'b1;
                pick = i;
                if (pred_policy != POL_BEST && pred_policy != POL_WORST)
                    break;
            end
            else if (pred_policy == POL_BEST && pred_len[i] < pred_len[pick])
                pick = i;
            else if (pred_policy == POL_WORST && pred_len[i] > pred_len[pick])
                pick = i;
        end
        if (!found)
        begin
            r.status = ST_NOFIT;
            return r;
        end
        r.alloc_addr = pred_start[pick];
        r.status = ST_OK;
        if (pred_len[pick] == size)
            drop_hole(pick);
        else
        begin
            pred_start[pick] = pred_start[pick] + size[15:0];
            pred_len[pick]   = pred_len[pick] - size;
        end
        return r;
    endfunction

    function automatic logic [1:0] predict_free(input logic [15:0] addr,
                                                input logic [16:0] size);
        longint rgn_end, new_end, nxt_end;
        int     pos;
        bit     join_prev, join_next;
        if (size == 0)
            return ST_IGNORED;
        rgn_end = longint'(addr) + size;
        if (rgn_end > MEM_BYTES)
            rgn_end = MEM_BYTES;
        pos = pred_count;
        for (int i = 0; i < pred_count; i++)
        begin
            if (pred_start[i] == addr)
                return ST_IGNORED;
            if (pred_start[i] > addr)
            begin
                pos = i;
                break;
            end
        end
        join_prev = pos > 0 &&
                    longint'(pred_start[pos - 1]) + pred_len[pos - 1] >= addr;
        join_next = pos < pred_count && longint'(pred_start[pos]) <= rgn_end;
        if (join_prev)
        begin
            new_end = longint'(pred_start[pos - 1]) + pred_len[pos - 1];
            if (rgn_end > new_end)
                new_end = rgn_end;
            if (join_next)
            begin
                nxt_end = longint'(pred_start[pos]) + pred_len[pos];
                if (nxt_end > new_end)
                    new_end = nxt_end;
                drop_hole(pos);
            end
            pred_len[pos - 1] = 17'(new_end - pred_start[pos - 1]);
        end
        else if (join_next)
        begin
            new_end = longint'(pred_start[pos]) + pred_len[pos];
            if (rgn_end > new_end)
                new_end = rgn_end;
            pred_start[pos] = addr;
            pred_len[pos]   = 17'(new_end - addr);
        end
        else
        begin
            if (pred_count >= MAX_HOLES)
                return ST_FULL;
            for (int i = pred_count; i > pos; i--)
            begin
                pred_start[i] = pred_start[i - 1];
                pred_len[i]   = pred_len[i - 1];
            end
            pred_start[pos] = addr;
            pred_len[pos]   = 17'(rgn_end - addr);
            pred_count++;
        end
        return ST_OK;
    endfunction

    function automatic alloc_rsp_t predict_response(input alloc_req_t r);
        alloc_rsp_t o;
        if (r.func == FUNC_ALLOC)
            o = predict_alloc(r.req_size);
        else
        begin
            o = '0;
            o.status = predict_free(r.req_addr, r.req_size);
        end
        return o;
    endfunction

    // Offer one request at the falling edge and hold it until accepted.
    // Valid stays up after acceptance until the next offer or a drain drops it.
    task automatic send_request(input alloc_req_t r);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid    <= 1'b1;
        req.func     <= r.func;
        req.req_size <= r.req_size;
        req.req_addr <= r.req_addr;
        do
            @(posedge clk);
        while (!req.ready);
        pending_rsps.push_back(predict_response(r));
        @(negedge clk);
    endtask

    // Same as send_request, but also check the predicted response against a typed value.
    task automatic send_checked(input alloc_req_t r, input alloc_rsp_t want);
        alloc_rsp_t p;
        send_request(r);
        p = pending_rsps[$];
        if (p !== want)
            report_mismatch("directed row", int'(p), int'(want));
    endtask

    // Wait for every response, then let a stray request finish before a write.
    task automatic drain_and_set_policy(input logic [1:0] pol);
        req.valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= pol;
        @(negedge clk);
        cfg_we <= 1'b0;
        pred_policy = pol;
    endtask

    // Random request: allocations, well-formed frees of previously granted blocks, and random frees.
    function automatic alloc_req_t random_request(ref logic [15:0] live_addr[$],
                                                 ref logic [16:0] live_size[$]);
        alloc_req_t r;
        int         k;
        int         pick;
        k = $urandom_range(99);
        r.req_addr = 16'($urandom);
        if (k < 45)
        begin
            r.func = FUNC_ALLOC;
            pick = $urandom_range(9);
            if (pick == 0)
                r.req_size = 17'($urandom);
            else if (pick == 1)
                r.req_size = 17'($urandom_range(65536, 60000));
            else
                r.req_size = 17'($urandom_range(1024));
        end
        else if (k < 85 && live_addr.size() != 0)
        begin
            pick = $urandom_range(live_addr.size() - 1);
            r.func = FUNC_FREE;
            r.req_addr = live_addr[pick];
            r.req_size = live_size[pick];
            live_addr.delete(pick);
            live_size.delete(pick);
        end
        else
        begin
            r.func = FUNC_FREE;
            r.req_size = ($urandom_range(3) == 0) ? 17'($urandom)
                                                   : 17'($urandom_range(300));
        end
        return r;
    endfunction

    // Response side: random back-pressure, plus one long hold-off.
    always @(negedge clk)
    begin
        if (hold_off_rsp)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare each accepted response with the oldest prediction.
    always @(posedge clk)
    begin
        alloc_rsp_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_rsps.size() == 0)
                report_mismatch("unexpected response status", rsp.status, -1);
            else
            begin
                want = pending_rsps.pop_front();
                if (rsp.status !== want.status)
                    report_mismatch("status", rsp.status, want.status);
                if (rsp.alloc_addr !== want.alloc_addr)
                    report_mismatch("alloc_addr", rsp.alloc_addr, want.alloc_addr);
            end
        end
    end

    initial
    begin
        alloc_req_t  dir_reqs [] ;
        alloc_rsp_t  dir_rsps [];
        bit          dir_typed [];
        logic [15:0] live_addr [$];
        logic [16:0] live_size [$];
        alloc_req_t  r;
        int          wait_cycles;

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.func = FUNC_ALLOC;
        req.req_size = '0;
        req.req_addr = '0;
        rsp.ready = 1'b0;
        error_count = 0;
        send_idle_pct = 12;
        recv_idle_pct = 80;
        hold_off_rsp = 1'b0;
        pred_count = 1;
        pred_start[0] = '0;
        pred_len[0] = 17'(MEM_BYTES);
        pred_policy = POL_FIRST;

        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed table: typed expectations where obvious, else predicted.
        dir_reqs = '{
            '{FUNC_ALLOC, 17'd0,     16'd0},      // size zero after reset
            '{FUNC_ALLOC, 17'd65537 & 17'h1ffff, 16'hffff}, // too big
            '{FUNC_ALLOC, 17'd65536, 16'd0},      // whole memory, table empties
            '{FUNC_ALLOC, 17'd1,     16'd0},      // empty table: no fit
            '{FUNC_FREE,  17'd16,    16'hfff0},   // insert into empty table
            '{FUNC_FREE,  17'd0,     16'd100},    // free of size zero
            '{FUNC_FREE,  17'd4,     16'hfff0},   // free at existing start
            '{FUNC_FREE,  17'h1ffff, 16'h0100},   // runs past end: clamped merge
            '{FUNC_FREE,  17'd16,    16'h0000},   // insert at bottom
            '{FUNC_FREE,  17'd16,    16'h0040},   // separate hole
            '{FUNC_FREE,  17'd48,    16'h0010},   // two-sided merge
            '{FUNC_ALLOC, 17'd256,   16'd0},
            '{FUNC_FREE,  17'd8,     16'h0100},   // separate hole
            '{FUNC_ALLOC, 17'd1,     16'h5555}
        };
        dir_typed = '{1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
        dir_rsps = '{
            '{16'd0, ST_OK}, '{16'd0, ST_NOFIT}, '{16'd0, ST_OK},
            '{16'd0, ST_NOFIT}, '{16'd0, ST_OK}, '{16'd0, ST_IGNORED},
            '{16'd0, ST_IGNORED}, '0, '0, '0, '0, '0, '0, '0
        };
        // Unused policy value behaves as first fit.
        drain_and_set_policy(2'd3);
        foreach (dir_reqs[i])
        begin
            if (dir_typed[i])
                send_checked(dir_reqs[i], dir_rsps[i]);
            else
                send_request(dir_reqs[i]);
        end

        // Fill the table with small holes to reach the full case.
        drain_and_set_policy(POL_FIRST);
        // Take a block over the fill area so each free lands in used memory.
        r.func = FUNC_ALLOC;
        r.req_size = 17'h04000;
        r.req_addr = '0;
        send_request(r);
        for (int i = 0; i < 40; i++)
        begin
            r.func = FUNC_FREE;
            r.req_addr = 16'(16'h2000 + i * 8);
            r.req_size = 17'd2;
            send_request(r);
        end
        for (int i = 0; i < 8; i++)
        begin
            r.func = FUNC_ALLOC;
            r.req_size = 17'(i % 3 + 1);
            r.req_addr = '0;
            send_request(r);
        end

        // Random phases over all policies and idle mixes.
        for (int phase = 0; phase < 6; phase++)
        begin
            drain_and_set_policy(2'(phase % 3));
            if (phase == 2)
            begin
                send_idle_pct = 80;
                recv_idle_pct = 12;
            end
            if (phase == 4)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            // Long receiver stall while requests keep coming.
            if (phase == 1)
            begin
                fork
                    begin
                        hold_off_rsp = 1'b1;
                        wait_cycles = 0;
                        while (wait_cycles < 600)
                        begin
                            @(posedge clk);
                            wait_cycles++;
                        end
                        hold_off_rsp = 1'b0;
                    end
                join_none
            end
            for (int n = 0; n < 56; n++)
            begin
                r = random_request(live_addr, live_size);
                send_request(r);
                if (r.func == FUNC_ALLOC && pending_rsps[$].status == ST_OK
                    && r.req_size != 0)
                begin
                    live_addr.push_back(pending_rsps[$].alloc_addr);
                    live_size.push_back(r.req_size);
                end
            end
        end

        req.valid <= 1'b0;
        while (pending_rsps.size() != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
